// ===== rtl/orb_pkg.sv =====
// shared types and constants for the overwriting ring buffer
package orb_pkg;

   // default geometry of the word store
   localparam int DEPTH_DEFAULT     = 64;
   localparam int WORD_BITS_DEFAULT = 64;

   // fixed field widths
   localparam int ENTRY_W = 64;
   localparam int COUNT_W = 7;
   localparam int KIND_W  = 2;
   localparam int CAP_W   = 7;

   // operation codes of an input item
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LIST   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // configuration register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 1'd0;
   localparam logic [CAP_W-1:0]     CAP_RESET    = 7'd64;

   // queue depths
   localparam int CMDQ_DEPTH = 2;
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ENTRY_W-1:0] entry_word;
      logic [COUNT_W-1:0] remove_count;
   } req_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] out_word;
      logic               last;
   } rsp_type;

   // classified command handed from the front to the back
   typedef struct packed {
      logic [KIND_W-1:0]  op;
      logic [ENTRY_W-1:0] word;
      logic [COUNT_W-1:0] count;
   } cmd_type;

endpackage

// ===== rtl/orb_ram.sv =====
// generic single write port ram with registered read
module orb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   we,
   input  logic [AW-1:0]          waddr,
   input  logic [WIDTH-1:0]       wdata,
   input  logic [AW-1:0]          raddr,
   output logic [WIDTH-1:0]       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/orb_front.sv =====
// input side: accepts items, drops unused codes and queues commands
module orb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  orb_pkg::req_type req_data,
   output logic             full,
   output logic             cmd_valid,
   output orb_pkg::cmd_type cmd,
   input  logic             cmd_pop
);
   localparam int QD = orb_pkg::CMDQ_DEPTH;
   localparam int PW = (QD > 1) ? $clog2(QD) : 1;
   localparam int CW = $clog2(QD + 1);

   orb_pkg::cmd_type q_ff [QD];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   orb_pkg::cmd_type cmd_in;
   logic keep;
   logic take;

   assign full      = (count_ff == CW'(QD));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign take      = cmd_pop & cmd_valid;
   // unused kind causes nothing, so it never enters the queue
   assign keep      = push & ~full & (req_data.kind != orb_pkg::KIND_UNUSED);

   always_comb begin
      cmd_in.op    = req_data.kind;
      cmd_in.word  = req_data.entry_word;
      cmd_in.count = req_data.remove_count;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (keep) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QD - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QD - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (keep && !take) begin
         count_in = count_ff + CW'(1);
      end else if (take && !keep) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end
endmodule

// ===== rtl/orb_rsp_queue.sv =====
// result queue between the word store and the result port
module orb_rsp_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rsp_push,
   input  orb_pkg::rsp_type                   rsp_in,
   input  logic                               pop,
   output logic                               empty,
   output orb_pkg::rsp_type                   rsp_data,
   output logic [orb_pkg::RSPQ_CNT_W-1:0]     rsp_count
);
   localparam int QD = orb_pkg::RSPQ_DEPTH;
   localparam int PW = (QD > 1) ? $clog2(QD) : 1;
   localparam int CW = orb_pkg::RSPQ_CNT_W;

   orb_pkg::rsp_type q_ff [QD];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic take;

   assign empty     = (count_ff == '0);
   assign rsp_data  = q_ff[rd_ptr_ff];
   assign rsp_count = count_ff;
   assign take      = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (rsp_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QD - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QD - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (rsp_push && !take) begin
         count_in = count_ff + CW'(1);
      end else if (take && !rsp_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         q_ff[wr_ptr_ff] <= rsp_in;
      end
   end
endmodule

// ===== rtl/orb_back.sv =====
// execution side: ring positions, occupancy, word store and list sequencing
module orb_back #(
   parameter int DEPTH     = orb_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = orb_pkg::WORD_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           clear,
   input  logic [orb_pkg::CAP_W-1:0]      capacity,
   input  logic                           cmd_valid,
   input  orb_pkg::cmd_type               cmd,
   output logic                           cmd_pop,
   input  logic [orb_pkg::RSPQ_CNT_W-1:0] rsp_count,
   output logic                           rsp_push,
   output orb_pkg::rsp_type               rsp_in
);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int CAP_W = orb_pkg::CAP_W;
   localparam int EW    = orb_pkg::ENTRY_W;
   localparam int RCW   = orb_pkg::RSPQ_CNT_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LIST = 1'b1;

   logic             state_ff, state_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [IDX_W-1:0] list_ptr_ff, list_ptr_in;
   logic [OCC_W-1:0] left_ff, left_in;
   logic             pend_ff, pend_in;
   logic             last_ff, last_in;

   logic [OCC_W-1:0]   cap_eff;
   logic [OCC_W-1:0]   rm_k;
   logic [OCC_W:0]     rm_sum;
   logic [RCW:0]       credit_sum;
   logic               credit;
   logic               ram_we;
   logic               issue;
   logic [WORD_BITS-1:0] ram_rdata;

   function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] p,
                                            input logic [OCC_W-1:0] c);
      logic [OCC_W-1:0] n;
      n = OCC_W'(p) + OCC_W'(1);
      adv = (n >= c) ? '0 : IDX_W'(n);
   endfunction

   // zero behaves as one, anything above the store depth saturates
   always_comb begin
      if (capacity > CAP_W'(DEPTH)) begin
         cap_eff = OCC_W'(DEPTH);
      end else if (capacity == '0) begin
         cap_eff = OCC_W'(1);
      end else begin
         cap_eff = OCC_W'(capacity);
      end
   end

   // remove count clamped to occupancy, positions wrap with one subtract
   assign rm_k   = (cmd.count > CAP_W'(occ_ff)) ? occ_ff : OCC_W'(cmd.count);
   assign rm_sum = (OCC_W + 1)'(rd_ptr_ff) + (OCC_W + 1)'(rm_k);

   // room in the result queue counting the read still in the ram
   assign credit_sum = (RCW + 1)'(rsp_count) + (RCW + 1)'(pend_ff);
   assign credit     = credit_sum < (RCW + 1)'(orb_pkg::RSPQ_DEPTH);

   always_comb begin
      state_in    = state_ff;
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      occ_in      = occ_ff;
      list_ptr_in = list_ptr_ff;
      left_in     = left_ff;
      cmd_pop     = 1'b0;
      ram_we      = 1'b0;
      issue       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  orb_pkg::KIND_APPEND: begin
                     ram_we    = 1'b1;
                     wr_ptr_in = adv(wr_ptr_ff, cap_eff);
                     if (occ_ff >= cap_eff) begin
                        rd_ptr_in = adv(rd_ptr_ff, cap_eff);
                     end else begin
                        occ_in = occ_ff + OCC_W'(1);
                     end
                  end
                  orb_pkg::KIND_REMOVE: begin
                     occ_in = occ_ff - rm_k;
                     if (rm_sum >= (OCC_W + 1)'(cap_eff)) begin
                        rd_ptr_in = IDX_W'(rm_sum - (OCC_W + 1)'(cap_eff));
                     end else begin
                        rd_ptr_in = IDX_W'(rm_sum);
                     end
                  end
                  orb_pkg::KIND_LIST: begin
                     if (occ_ff != '0) begin
                        list_ptr_in = rd_ptr_ff;
                        left_in     = occ_ff;
                        state_in    = ST_LIST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LIST: begin
            if (credit) begin
               issue       = 1'b1;
               list_ptr_in = adv(list_ptr_ff, cap_eff);
               left_in     = left_ff - OCC_W'(1);
               if (left_ff == OCC_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (clear) begin
         rd_ptr_in = '0;
         wr_ptr_in = '0;
         occ_in    = '0;
      end
   end

   assign pend_in = issue;
   assign last_in = (left_ff == OCC_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         occ_ff    <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         occ_ff    <= occ_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      list_ptr_ff <= list_ptr_in;
      left_ff     <= left_in;
      if (issue) begin
         last_ff <= last_in;
      end
   end

   orb_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_ptr_ff),
      .wdata (cmd.word[WORD_BITS-1:0]),
      .raddr (list_ptr_ff),
      .rdata (ram_rdata)
   );

   assign rsp_push        = pend_ff;
   assign rsp_in.out_word = EW'(ram_rdata);
   assign rsp_in.last     = last_ff;
endmodule

// ===== rtl/overwriting_ring_buffer_top.sv =====
// top level of the overwriting ring buffer with its register port
//
// channel   ports                                  transfer when
// request   push, full, req_data                   push && !full
// response  empty, pop, rsp_data                   pop && !empty
// csr       psel, penable, pwrite, paddr, pwdata,  psel && penable && pwrite && pready
//           prdata, pready
//
// append and remove finish in the execution unit as the command is taken; a list then
// reads one word per cycle while the result queue has room, paced by the store's
// registered read and the four-entry result queue that it fills.
// reset clears positions, occupancy and queues at once; the store needs no clearing.
// a two-entry command queue takes items until full while a list runs or results stall.
module overwriting_ring_buffer_top #(
   parameter int DEPTH     = orb_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = orb_pkg::WORD_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  orb_pkg::req_type                 req_data,
   output logic                             empty,
   input  logic                             pop,
   output orb_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [orb_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [orb_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [orb_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   localparam int CAP_W = orb_pkg::CAP_W;
   localparam int DW    = orb_pkg::CSR_DATA_W;

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [orb_pkg::CSR_IDX_W-1:0] csr_idx;
   logic csr_wr;
   logic clear;

   logic             cmd_valid;
   orb_pkg::cmd_type cmd;
   logic             cmd_pop;
   logic             rsp_push;
   orb_pkg::rsp_type rsp_in;
   logic [orb_pkg::RSPQ_CNT_W-1:0] rsp_count;

   assign pready  = 1'b1;
   assign csr_idx = paddr[orb_pkg::CSR_ADDR_W-1:2];
   assign csr_wr  = psel & penable & pwrite & pready;
   // a capacity write also empties the ring
   assign clear   = csr_wr && (csr_idx == orb_pkg::CSR_CAPACITY);

   assign capacity_in = clear ? pwdata[CAP_W-1:0] : capacity_ff;
   assign prdata      = (csr_idx == orb_pkg::CSR_CAPACITY) ? DW'(capacity_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= orb_pkg::CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   orb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   orb_back #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear),
      .capacity  (capacity_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_in    (rsp_in)
   );

   orb_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .rsp_push  (rsp_push),
      .rsp_in    (rsp_in),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data),
      .rsp_count (rsp_count)
   );
endmodule
